// ----- hdl/roet_pkg.sv -----
// Shared constants, status codes and types of the open entry table.
package roet_pkg;

   // Table geometry and on-disk layout
   localparam int TABLE_SLOTS       = 64;
   localparam int ENTRIES_PER_BLOCK = 64;
   localparam int ENTRY_BYTES       = 64;

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W  = 8;
   localparam int NUM_W  = 16;
   localparam int BLK_W  = 16;
   localparam int OFF_W  = 12;

   // Operation codes
   localparam logic [1:0] OP_GET   = 2'd0;
   localparam logic [1:0] OP_PUT   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_LOADED    = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RELEASED  = 3'd3;
   localparam logic [2:0] ST_WRITEBACK = 3'd4;
   localparam logic [2:0] ST_IGNORED   = 3'd5;
   localparam logic [2:0] ST_SATURATED = 3'd6;
   localparam logic [2:0] ST_CLEARED   = 3'd7;

   // Request to the address unit
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] number;
   } loc_req_type;

   // Answer of the address unit
   typedef struct packed {
      logic             done;
      logic [BLK_W-1:0] disk_block;
      logic [OFF_W-1:0] byte_offset;
   } loc_rsp_type;

endpackage

// ----- hdl/roet_locate.sv -----
// Address unit: finds the disk block and byte offset of an entry number.
module roet_locate (
   input  logic                            clock,
   input  logic                            reset,
   input  roet_pkg::loc_req_type           loc_req,
   input  logic [roet_pkg::BLK_W-1:0]      first_table_block,
   output roet_pkg::loc_rsp_type           loc_rsp
);
   import roet_pkg::*;

   logic              done_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [OFF_W-1:0]  off_ff;

   logic [NUM_W-1:0]  quo;
   logic [NUM_W-1:0]  rem;
   logic [31:0]       off_prod;

   // Split the entry number by the power-of-two block size
   assign quo      = loc_req.number / NUM_W'(ENTRIES_PER_BLOCK);
   assign rem      = loc_req.number % NUM_W'(ENTRIES_PER_BLOCK);
   assign off_prod = 32'(rem) * 32'(ENTRY_BYTES);

   // Flag the answer in the cycle after the request
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= loc_req.start;
      end
   end

   // Form block and offset, both wrapping at their widths
   always_ff @(posedge clock) begin
      if (loc_req.start) begin
         blk_ff <= BLK_W'(quo) + first_table_block;
         off_ff <= off_prod[OFF_W-1:0];
      end
   end

   assign loc_rsp.done        = done_ff;
   assign loc_rsp.disk_block  = blk_ff;
   assign loc_rsp.byte_offset = off_ff;

endmodule

// ----- hdl/refcounted_open_entry_table_top.sv -----
// Top level of the reference-counted open entry table.
//
// Usage: an item on the req_ channel carries an operation (get by entry
// number, put by slot, clear all counts). Each item except the unused code
// three gives one item on the rsp_ channel with status, slot, count after,
// and for a load or write-back the disk block and byte offset.
// csr_ writes first_table_block; the user must keep such writes to times the
// block is idle, which the block itself does not enforce. csr_ready is always high.
// A get scans the table one slot a cycle through the table memory read port
// and finishes on a hit, or after the last slot with a full table or a load;
// a load also passes through the address unit. A put reads its slot at
// acceptance and finishes, or passes through the address unit for a
// write-back. A clear goes straight to the finish state.
// The block takes one item at a time; for an item that gives a result,
// req_ready is low from acceptance until the result sits in the output register.
// Reset clears every slot's valid bit at once, so no clearing pass is needed;
// first_table_block returns to 2.
// When the receiver stalls, the output register holds the result; the block
// may take one more item and holds its result until the output register is free.
module refcounted_open_entry_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [roet_pkg::NUM_W-1:0]    req_entry_number,
   input  logic [5:0]                    req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [5:0]                    rsp_result_slot,
   output logic [roet_pkg::CNT_W-1:0]    rsp_ref_count_after,
   output logic [roet_pkg::BLK_W-1:0]    rsp_disk_block,
   output logic [roet_pkg::OFF_W-1:0]    rsp_byte_offset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [roet_pkg::BLK_W-1:0]    csr_first_table_block
);
   import roet_pkg::*;

   localparam int MEM_W = NUM_W + CNT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_PUTRD = 3'd2;
   localparam logic [2:0] S_LOC   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]         state_ff;
   logic [BLK_W-1:0]   first_blk_ff;
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [MEM_W-1:0]   mem_ff [TABLE_SLOTS];
   logic [MEM_W-1:0]   rd_data_ff;
   logic               vbit_ff;

   logic [SLOT_W:0]    scan_ff;
   logic               pend_ff;
   logic [SLOT_W-1:0]  chk_idx_ff;
   logic               free_found_ff;
   logic [SLOT_W-1:0]  free_idx_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [SLOT_W-1:0]  slot_idx_ff;

   logic [2:0]         res_status_ff;
   logic [SLOT_W-1:0]  res_slot_ff;
   logic [CNT_W-1:0]   res_cnt_ff;
   logic [BLK_W-1:0]   res_blk_ff;
   logic [OFF_W-1:0]   res_off_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [5:0]         rsp_slot_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic [BLK_W-1:0]   rsp_blk_ff;
   logic [OFF_W-1:0]   rsp_off_ff;

   logic               req_acc;
   logic               issue;
   logic [SLOT_W-1:0]  rd_addr;
   logic [SLOT_W-1:0]  put_idx;
   logic               put_in_range;
   logic [CNT_W-1:0]   rd_cnt;
   logic [NUM_W-1:0]   rd_id;
   logic               rd_live;
   logic               hit;
   logic               is_free;
   logic               last;
   logic               free_any;
   logic [SLOT_W-1:0]  free_sel;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [MEM_W-1:0]   wr_data;
   logic               out_free;
   loc_req_type        loc_req;
   loc_rsp_type        loc_rsp;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_acc      = req_valid && req_ready;
   assign csr_ready    = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   assign put_idx      = SLOT_W'(req_slot);
   assign put_in_range = 32'(req_slot) < TABLE_SLOTS;
   assign issue        = (state_ff == S_SCAN) && (scan_ff != (SLOT_W + 1)'(TABLE_SLOTS));
   assign rd_addr      = (state_ff == S_IDLE) ? put_idx :
                         (issue ? scan_ff[SLOT_W-1:0] : '0);

   // Decode the slot read back from the table
   assign rd_cnt   = rd_data_ff[CNT_W-1:0];
   assign rd_id    = rd_data_ff[MEM_W-1:CNT_W];
   assign rd_live  = vbit_ff && (rd_cnt != '0);
   assign hit      = pend_ff && rd_live && (rd_id == num_ff);
   assign is_free  = pend_ff && !rd_live;
   assign last     = pend_ff && (chk_idx_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign free_any = free_found_ff || is_free;
   assign free_sel = free_found_ff ? free_idx_ff : chk_idx_ff;

   // Pick the table write and the address unit request
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = chk_idx_ff;
      wr_data        = rd_data_ff;
      loc_req.start  = 1'b0;
      loc_req.number = num_ff;
      case (state_ff)
         S_SCAN: begin
            if (hit) begin
               if (rd_cnt != '1) begin
                  wr_en   = 1'b1;
                  wr_data = {rd_id, CNT_W'(rd_cnt + 1'b1)};
               end
            end else if (last && free_any) begin
               wr_en         = 1'b1;
               wr_addr       = free_sel;
               wr_data       = {num_ff, CNT_W'(1)};
               loc_req.start = 1'b1;
            end
         end
         S_PUTRD: begin
            if (rd_live) begin
               wr_en   = 1'b1;
               wr_addr = slot_idx_ff;
               wr_data = {rd_id, CNT_W'(rd_cnt - 1'b1)};
               if (rd_cnt == CNT_W'(1)) begin
                  loc_req.start  = 1'b1;
                  loc_req.number = rd_id;
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
      vbit_ff    <= valid_ff[rd_addr];
   end

   // Hold valid bits and the configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         first_blk_ff <= BLK_W'(2);
      end else begin
         if (csr_valid && csr_ready) begin
            first_blk_ff <= csr_first_table_block;
         end
         if (req_acc && (req_operation == OP_CLEAR)) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Sequence one item through scan, put, address unit and finish
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         scan_ff       <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  num_ff        <= req_entry_number;
                  slot_idx_ff   <= put_idx;
                  scan_ff       <= '0;
                  pend_ff       <= 1'b0;
                  free_found_ff <= 1'b0;
                  res_cnt_ff    <= '0;
                  res_blk_ff    <= '0;
                  res_off_ff    <= '0;
                  case (req_operation)
                     OP_GET: begin
                        res_slot_ff <= '0;
                        state_ff    <= S_SCAN;
                     end
                     OP_PUT: begin
                        res_slot_ff <= put_idx;
                        if (put_in_range) begin
                           state_ff <= S_PUTRD;
                        end else begin
                           res_status_ff <= ST_IGNORED;
                           state_ff      <= S_FIN;
                        end
                     end
                     OP_CLEAR: begin
                        res_slot_ff   <= '0;
                        res_status_ff <= ST_CLEARED;
                        state_ff      <= S_FIN;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               pend_ff <= issue;
               if (issue) begin
                  chk_idx_ff <= scan_ff[SLOT_W-1:0];
                  scan_ff    <= scan_ff + 1'b1;
               end
               if (hit) begin
                  res_slot_ff <= chk_idx_ff;
                  if (rd_cnt == '1) begin
                     res_status_ff <= ST_SATURATED;
                     res_cnt_ff    <= rd_cnt;
                  end else begin
                     res_status_ff <= ST_HIT;
                     res_cnt_ff    <= CNT_W'(rd_cnt + 1'b1);
                  end
                  state_ff <= S_FIN;
               end else if (last) begin
                  if (free_any) begin
                     res_status_ff <= ST_LOADED;
                     res_slot_ff   <= free_sel;
                     res_cnt_ff    <= CNT_W'(1);
                     state_ff      <= S_LOC;
                  end else begin
                     res_status_ff <= ST_FULL;
                     state_ff      <= S_FIN;
                  end
               end else if (is_free && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= chk_idx_ff;
               end
            end
            S_PUTRD: begin
               res_slot_ff <= slot_idx_ff;
               if (!rd_live) begin
                  res_status_ff <= ST_IGNORED;
                  state_ff      <= S_FIN;
               end else if (rd_cnt == CNT_W'(1)) begin
                  res_status_ff <= ST_WRITEBACK;
                  state_ff      <= S_LOC;
               end else begin
                  res_status_ff <= ST_RELEASED;
                  res_cnt_ff    <= CNT_W'(rd_cnt - 1'b1);
                  state_ff      <= S_FIN;
               end
            end
            S_LOC: begin
               if (loc_rsp.done) begin
                  res_blk_ff <= loc_rsp.disk_block;
                  res_off_ff <= loc_rsp.byte_offset;
                  state_ff   <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Load the output register when it is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_FIN) && out_free) begin
         rsp_valid_ff  <= 1'b1;
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= 6'(res_slot_ff);
         rsp_cnt_ff    <= res_cnt_ff;
         rsp_blk_ff    <= res_blk_ff;
         rsp_off_ff    <= res_off_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   roet_locate u_locate (
      .clock             (clock),
      .reset             (reset),
      .loc_req           (loc_req),
      .first_table_block (first_blk_ff),
      .loc_rsp           (loc_rsp)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_slot     = rsp_slot_ff;
   assign rsp_ref_count_after = rsp_cnt_ff;
   assign rsp_disk_block      = rsp_blk_ff;
   assign rsp_byte_offset     = rsp_off_ff;

endmodule

// ----- hdl/roet_checker.sv -----
// Port-level checks of the open entry table, bound to the top level.
module roet_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [5:0]                    rsp_result_slot,
   input logic [roet_pkg::CNT_W-1:0]    rsp_ref_count_after,
   input logic [roet_pkg::BLK_W-1:0]    rsp_disk_block,
   input logic [roet_pkg::OFF_W-1:0]    rsp_byte_offset
);
   import roet_pkg::*;

   logic req_known;
   logic zero_status;

   // Flag operations that give a result and statuses with all-zero fields
   assign req_known   = req_operation inside {OP_GET, OP_PUT, OP_CLEAR};
   assign zero_status = rsp_status inside {ST_FULL, ST_CLEARED};

   // No result is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Drop ready while an item is being worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_known) |=> !req_ready)
      else $error("ready high after accepting an item");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_result_slot)
                                     && $stable(rsp_ref_count_after)))
      else $error("stalled result changed");

   // Full and cleared results carry zero fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && zero_status)
      |-> (rsp_result_slot == '0 && rsp_ref_count_after == '0
           && rsp_disk_block == '0 && rsp_byte_offset == '0))
      else $error("full or cleared result with nonzero fields");

endmodule

bind refcounted_open_entry_table_top roet_checker u_roet_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_operation       (req_operation),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_result_slot     (rsp_result_slot),
   .rsp_ref_count_after (rsp_ref_count_after),
   .rsp_disk_block      (rsp_disk_block),
   .rsp_byte_offset     (rsp_byte_offset)
);
